>>> rtl/imufp_pkg.sv
package imufp_pkg;

    localparam int SAMPLE_BYTES = 32;
    localparam int STORE_AW = $clog2(SAMPLE_BYTES);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] ST_INCOMPLETE  = 2'd0;
    localparam logic [1:0] ST_OK          = 2'd1;
    localparam logic [1:0] ST_MISMATCH    = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_SAMPLE_ID   = 2'd2;
    localparam logic [1:0] REG_MAX_SKIP    = 2'd3;

    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h5A;
    localparam logic [7:0]  RST_SAMPLE_ID   = 8'h01;
    localparam logic [15:0] RST_MAX_SKIP    = 16'd1024;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  sample_msg_id;
        logic [15:0] max_skip_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic [63:0]        time_us;
    } t_result;

endpackage

>>> rtl/imufp_front.sv
module imufp_front
    import imufp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  t_cfg        i_cfg,
    output t_result     o_res
);

    localparam logic [2:0] PH_SYNC1   = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_ID      = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CK_A    = 3'd6;
    localparam logic [2:0] PH_CK_B    = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_store [SAMPLE_BYTES];

    logic [7:0]  sum_a_add;
    logic [15:0] len_full;
    logic        known;
    logic        clear;
    logic        store_we;
    logic        decode;
    logic [1:0]  status;
    logic [8*SAMPLE_BYTES-1:0] sample;

    always_comb begin
        sum_a_add = r_sum_a + i_byte;
        len_full  = {i_byte, r_len[7:0]};
        known     = (r_id == i_cfg.sample_msg_id);
        n_phase   = r_phase;
        n_id      = r_id;
        n_len     = r_len;
        n_count   = r_count;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        clear     = 1'b0;
        store_we  = 1'b0;
        decode    = 1'b0;
        status    = ST_INCOMPLETE;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_cfg.sync_first) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_phase = PH_ID;
                end else if (i_byte == i_cfg.sync_first) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = len_full;
                n_sum_a = sum_a_add;
                n_sum_b = r_sum_b + sum_a_add;
                // drop a sample frame of the wrong size or an over-long foreign frame
                if ((known && len_full != 16'(SAMPLE_BYTES)) ||
                    (!known && len_full > i_cfg.max_skip_length)) begin
                    clear = 1'b1;
                end else begin
                    n_count = 16'd0;
                    n_phase = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a  = sum_a_add;
                n_sum_b  = r_sum_b + sum_a_add;
                store_we = known;
                n_count  = r_count + 16'd1;
                if (n_count == r_len) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                if (i_byte != r_sum_a) begin
                    clear  = 1'b1;
                    status = ST_MISMATCH;
                end else begin
                    n_phase = PH_CK_B;
                end
            end
            PH_CK_B: begin
                clear = 1'b1;
                if (i_byte != r_sum_b) begin
                    status = ST_MISMATCH;
                end else if (!known) begin
                    status = ST_UNSUPPORTED;
                end else begin
                    status = ST_OK;
                    decode = 1'b1;
                end
            end
            default: begin
                clear = 1'b1;
            end
        endcase
        if (clear) begin
            n_phase = PH_SYNC1;
            n_id    = 8'd0;
            n_len   = 16'd0;
            n_count = 16'd0;
            n_sum_a = 8'd0;
            n_sum_b = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_count[STORE_AW-1:0]] <= i_byte;
        end
    end

    // little-endian image of the stored payload, zeroed unless the frame checks out
    always_comb begin
        for (int k = 0; k < SAMPLE_BYTES; k++) begin
            sample[8*k +: 8] = decode ? r_store[k] : 8'd0;
        end
    end

    always_comb begin
        o_res.status  = status;
        o_res.accel_x = sample[31:0];
        o_res.accel_y = sample[63:32];
        o_res.accel_z = sample[95:64];
        o_res.gyro_x  = sample[127:96];
        o_res.gyro_y  = sample[159:128];
        o_res.gyro_z  = sample[191:160];
        o_res.time_us = sample[255:192];
    end

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_count < r_len)
        else $error("payload counter reached frame length inside payload");

    a_status_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status != ST_INCOMPLETE |-> (r_phase == PH_CK_A || r_phase == PH_CK_B))
        else $error("frame status outside checksum phases");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_step) && $past(clear) |-> r_phase == PH_SYNC1 && r_sum_a == 8'd0
            && r_sum_b == 8'd0)
        else $error("frame state not cleared after drop");

endmodule

>>> rtl/imufp_queue.sv
module imufp_queue
    import imufp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count did not drop on pop");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("queue full and empty at once");

endmodule

>>> rtl/imu_frame_parser_core.sv
// Each accepted byte has its result written into the queue at the edge that accepts it.
// Throughput: one byte per cycle while the queue has room; the parser steps every byte
// through one state update; the queue (QUEUE_DEPTH entries) absorbs result-side stalls.
// Reset: synchronous, active low; parser hunts the first sync byte, queue empties,
// registers return to their defaults. The payload store is not cleared.
module imu_frame_parser_core
    import imufp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream in
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    // results out
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic signed [31:0] o_gyro_x,
    output logic signed [31:0] o_gyro_y,
    output logic signed [31:0] o_gyro_z,
    output logic [63:0]        o_time_us,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    r_cfg;
    t_result front_res;
    t_result head;
    logic    step;
    logic    cfg_wr;
    logic [1:0] reg_idx;

    // Register file: one word per register, index from the word address.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first      <= RST_SYNC_FIRST;
            r_cfg.sync_second     <= RST_SYNC_SECOND;
            r_cfg.sample_msg_id   <= RST_SAMPLE_ID;
            r_cfg.max_skip_length <= RST_MAX_SKIP;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SYNC_FIRST:  r_cfg.sync_first      <= pwdata[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second     <= pwdata[7:0];
                REG_SAMPLE_ID:   r_cfg.sample_msg_id   <= pwdata[7:0];
                REG_MAX_SKIP:    r_cfg.max_skip_length <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SYNC_FIRST:  prdata = {24'd0, r_cfg.sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_cfg.sync_second};
            REG_SAMPLE_ID:   prdata = {24'd0, r_cfg.sample_msg_id};
            REG_MAX_SKIP:    prdata = {16'd0, r_cfg.max_skip_length};
            default:         prdata = 32'd0;
        endcase
    end

    // Front: advance the parser on every accepted byte; it only stalls when the
    // result queue has no room.
    assign step = push && !full;

    imufp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_rx_byte),
        .i_cfg   (r_cfg),
        .o_res   (front_res)
    );

    // Back: hold each result until the consumer takes the transfer.
    imufp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (front_res),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    assign o_status  = head.status;
    assign o_accel_x = head.accel_x;
    assign o_accel_y = head.accel_y;
    assign o_accel_z = head.accel_z;
    assign o_gyro_x  = head.gyro_x;
    assign o_gyro_y  = head.gyro_y;
    assign o_gyro_z  = head.gyro_z;
    assign o_time_us = head.time_us;

endmodule
